### rtl/core/prq_pkg.sv
// Shared types and constants for the priority ready queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prq_pkg;

    localparam int TASK_CNT     = 32;
    localparam int TASK_W       = 5;
    localparam int NUM_LEVELS   = 256;
    localparam int LEVEL_W      = 8;
    localparam int GRP_SIZE     = 16;
    localparam int GRP_W        = 4;
    localparam int NUM_GRPS     = NUM_LEVELS / GRP_SIZE;
    localparam int GIDX_W       = LEVEL_W - GRP_W;

    localparam logic [TASK_W-1:0]  IDLE_TASK    = '0;
    localparam logic [LEVEL_W-1:0] LOWEST_LEVEL = LEVEL_W'(NUM_LEVELS - 1);

    localparam logic [1:0] OP_ENQUEUE  = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;

    localparam logic [1:0] MODE_STRICT = 2'd0;
    localparam logic [1:0] MODE_YIELD  = 2'd1;
    localparam logic [1:0] MODE_EXIT   = 2'd2;

    // per-task entry: list links and level
    typedef struct packed {
        logic [TASK_W-1:0]  next;
        logic [TASK_W-1:0]  prev;
        logic [LEVEL_W-1:0] lvl;
    } t_task_ent;

    typedef struct packed {
        logic              en_next;
        logic              en_prev;
        logic              en_lvl;
        logic [TASK_W-1:0] addr;
        t_task_ent         ent;
    } t_tm_wr;

    typedef struct packed {
        logic [TASK_W-1:0] head;
        logic [TASK_W-1:0] tail;
    } t_lvl_ent;

    typedef struct packed {
        logic               en;
        logic [LEVEL_W-1:0] addr;
        t_lvl_ent           ent;
    } t_lm_wr;

    typedef struct packed {
        logic               set;
        logic               clr;
        logic [LEVEL_W-1:0] level;
    } t_map_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP0,
        S_APP1,
        S_APP2,
        S_UL0,
        S_UL1,
        S_UL2,
        S_UL3,
        S_D0,
        S_D1,
        S_D2,
        S_DAPP,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

### rtl/core/prq_task_mem.sv
// Per-task memory: next/prev links and queued level, registered read.
// Depends on prq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prq_task_mem (
    input  wire logic                          i_clk,
    input  wire prq_pkg::t_tm_wr               i_wr,
    input  wire logic                          i_rd_en,
    input  wire logic [prq_pkg::TASK_W-1:0]    i_rd_addr,
    output prq_pkg::t_task_ent                 o_rd_data
);

    prq_pkg::t_task_ent mem [prq_pkg::TASK_CNT];
    prq_pkg::t_task_ent r_rd_data;

    // per-field write enables
    always_ff @(posedge i_clk) begin
        if (i_wr.en_next) begin
            mem[i_wr.addr].next <= i_wr.ent.next;
        end
        if (i_wr.en_prev) begin
            mem[i_wr.addr].prev <= i_wr.ent.prev;
        end
        if (i_wr.en_lvl) begin
            mem[i_wr.addr].lvl <= i_wr.ent.lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### rtl/core/prq_level_mem.sv
// Per-level head/tail memory, registered read.
// Lowest level reads as idle task until first written. Depends on prq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prq_level_mem (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire prq_pkg::t_lm_wr               i_wr,
    input  wire logic                          i_rd_en,
    input  wire logic [prq_pkg::LEVEL_W-1:0]   i_rd_addr,
    output prq_pkg::t_lvl_ent                  o_rd_data
);

    prq_pkg::t_lvl_ent mem [prq_pkg::NUM_LEVELS];
    prq_pkg::t_lvl_ent r_rd_data;
    logic              r_low_init;
    logic              r_rd_low;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.ent;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // lowest level still at its reset contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_init <= 1'b1;
            r_rd_low   <= 1'b0;
        end else begin
            if (i_wr.en && i_wr.addr == prq_pkg::LOWEST_LEVEL) begin
                r_low_init <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_low <= r_low_init && (i_rd_addr == prq_pkg::LOWEST_LEVEL);
            end
        end
    end

    always_comb begin
        o_rd_data = r_rd_data;
        if (r_rd_low) begin
            o_rd_data.head = prq_pkg::IDLE_TASK;
            o_rd_data.tail = prq_pkg::IDLE_TASK;
        end
    end

endmodule
`default_nettype wire

### rtl/core/prq_level_map.sv
// Non-empty level bitmap and two-stage priority encoder (group, then bit).
// Depends on prq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prq_level_map (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire prq_pkg::t_map_ctl             i_ctl,
    input  wire logic                          i_find,
    input  wire logic [prq_pkg::LEVEL_W-1:0]   i_chk_level,
    output logic                               o_chk_set,
    output logic [prq_pkg::LEVEL_W-1:0]        o_top
);

    logic [prq_pkg::NUM_LEVELS-1:0] r_map;
    logic [prq_pkg::GRP_W-1:0]      r_grp;
    logic [prq_pkg::NUM_GRPS-1:0]   grp_any;
    logic [prq_pkg::GRP_W-1:0]      first_grp;
    logic [prq_pkg::GRP_SIZE-1:0]   grp_bits;
    logic [prq_pkg::GIDX_W-1:0]     first_bit;
    logic                           bit_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= {1'b1, {(prq_pkg::NUM_LEVELS-1){1'b0}}};
        end else begin
            if (i_ctl.set) begin
                r_map[i_ctl.level] <= 1'b1;
            end else if (i_ctl.clr) begin
                r_map[i_ctl.level] <= 1'b0;
            end
        end
    end

    // is the given level non-empty
    assign o_chk_set = r_map[i_chk_level];

    // stage 1: first non-empty group
    always_comb begin
        first_grp = '1;
        for (int g = 0; g < prq_pkg::NUM_GRPS; g++) begin
            grp_any[g] = |r_map[g*prq_pkg::GRP_SIZE +: prq_pkg::GRP_SIZE];
        end
        for (int g = prq_pkg::NUM_GRPS - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
                first_grp = prq_pkg::GRP_W'(g);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_find) begin
            r_grp <= first_grp;
        end
    end

    // stage 2: first set bit inside that group
    always_comb begin
        grp_bits  = r_map[r_grp*prq_pkg::GRP_SIZE +: prq_pkg::GRP_SIZE];
        first_bit = '1;
        bit_found = 1'b0;
        for (int b = prq_pkg::GRP_SIZE - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                first_bit = prq_pkg::GIDX_W'(b);
                bit_found = 1'b1;
            end
        end
        o_top = bit_found ? {r_grp, first_bit} : prq_pkg::LOWEST_LEVEL;
    end

endmodule
`default_nettype wire

### rtl/core/priority_fifo_ready_queue.sv
// Priority ready queue top: stream handshakes, op sequencer, memories.
// Depends on prq_pkg, prq_task_mem, prq_level_mem, prq_level_map.
// Errors and op 3 go straight to the response; enqueue appends, remove unlinks,
// dispatch picks the top level (pop, unlink, re-append). One word in work: the
// next is accepted only after the last result enters the output register, so
// output stalls delay it. Reset: sync, low, task 0 queued.
`timescale 1ns / 1ps
`default_nettype none
module priority_fifo_ready_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] task_id, [12:5] task_level, [17:13] running_task,
    // [25:18] running_level, [27:26] dispatch_mode, [31:28] zero
    input  wire logic [31:0] s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [4:0] next_task, [5] switched, [6] status, [7] zero
    output logic [7:0]       m_axis_tdata
);

    localparam int TW = prq_pkg::TASK_W;
    localparam int LW = prq_pkg::LEVEL_W;

    prq_pkg::t_state r_state, n_state;

    // latched request
    logic [1:0]    r_op, n_op;
    logic [TW-1:0] r_run, n_run;
    logic [LW-1:0] r_rlv, n_rlv;
    logic [1:0]    r_mode, n_mode;

    // working registers
    logic [TW-1:0] r_app_t, n_app_t;    // task being appended
    logic [LW-1:0] r_app_lv, n_app_lv;  // level it goes to
    logic [TW-1:0] r_app_pv, n_app_pv;  // old tail of that level
    logic [TW-1:0] r_ul_t, n_ul_t;      // task being unlinked
    logic [TW-1:0] r_p, n_p;
    logic [TW-1:0] r_n, n_n;
    logic [LW-1:0] r_lv, n_lv;

    // result being built
    logic [TW-1:0] r_res_next, n_res_next;
    logic          r_res_sw, n_res_sw;
    logic          r_res_st, n_res_st;

    // output register
    logic          r_m_valid, n_m_valid;
    logic [7:0]    r_m_data, n_m_data;

    logic [prq_pkg::TASK_CNT-1:0] r_queued, n_queued;

    // memory and bitmap control
    prq_pkg::t_tm_wr    tm_wr;
    logic               tm_rd_en;
    logic [TW-1:0]      tm_rd_addr;
    prq_pkg::t_task_ent tm_rd;
    prq_pkg::t_lm_wr    lm_wr;
    logic               lm_rd_en;
    logic [LW-1:0]      lm_rd_addr;
    prq_pkg::t_lvl_ent  lm_rd;
    prq_pkg::t_map_ctl  map_ctl;
    logic               map_find;
    logic [LW-1:0]      top_lv;

    logic               in_acc;
    logic               take;
    logic               at_head;
    logic               at_tail;
    logic               lv_nonempty;

    prq_task_mem u_task_mem (
        .i_clk     (i_clk),
        .i_wr      (tm_wr),
        .i_rd_en   (tm_rd_en),
        .i_rd_addr (tm_rd_addr),
        .o_rd_data (tm_rd)
    );

    prq_level_mem u_level_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (lm_wr),
        .i_rd_en   (lm_rd_en),
        .i_rd_addr (lm_rd_addr),
        .o_rd_data (lm_rd)
    );

    // bitmap bit of the append level, used to pick head or tail link
    prq_level_map u_level_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (map_ctl),
        .i_find      (map_find),
        .i_chk_level (r_app_lv),
        .o_chk_set   (lv_nonempty),
        .o_top       (top_lv)
    );

    assign s_axis_tready = (r_state == prq_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= prq_pkg::S_IDLE;
            r_m_valid <= 1'b0;
            r_queued  <= prq_pkg::TASK_CNT'(1);
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_queued  <= n_queued;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_run      <= n_run;
        r_rlv      <= n_rlv;
        r_mode     <= n_mode;
        r_app_t    <= n_app_t;
        r_app_lv   <= n_app_lv;
        r_app_pv   <= n_app_pv;
        r_ul_t     <= n_ul_t;
        r_p        <= n_p;
        r_n        <= n_n;
        r_lv       <= n_lv;
        r_res_next <= n_res_next;
        r_res_sw   <= n_res_sw;
        r_res_st   <= n_res_st;
        r_m_data   <= n_m_data;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_run      = r_run;
        n_rlv      = r_rlv;
        n_mode     = r_mode;
        n_app_t    = r_app_t;
        n_app_lv   = r_app_lv;
        n_app_pv   = r_app_pv;
        n_ul_t     = r_ul_t;
        n_p        = r_p;
        n_n        = r_n;
        n_lv       = r_lv;
        n_res_next = r_res_next;
        n_res_sw   = r_res_sw;
        n_res_st   = r_res_st;
        n_m_data   = r_m_data;
        n_queued   = r_queued;
        n_m_valid  = r_m_valid && !m_axis_tready;

        tm_wr      = '0;
        tm_rd_en   = 1'b0;
        tm_rd_addr = r_ul_t;
        lm_wr      = '0;
        lm_rd_en   = 1'b0;
        lm_rd_addr = r_app_lv;
        map_ctl    = '0;
        map_find   = 1'b0;

        at_head     = (lm_rd.head == r_ul_t);
        at_tail     = (lm_rd.tail == r_ul_t);

        case (r_mode)
            prq_pkg::MODE_EXIT:  take = 1'b1;
            prq_pkg::MODE_YIELD: take = (top_lv <= r_rlv);
            default:             take = (top_lv < r_rlv);
        endcase

        case (r_state)
            prq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op       = s_axis_tuser;
                    n_run      = s_axis_tdata[17:13];
                    n_rlv      = s_axis_tdata[25:18];
                    n_mode     = s_axis_tdata[27:26];
                    n_res_next = s_axis_tdata[4:0];
                    n_res_sw   = 1'b0;
                    n_res_st   = 1'b0;
                    n_app_t    = s_axis_tdata[4:0];
                    n_app_lv   = s_axis_tdata[12:5];
                    n_ul_t     = s_axis_tdata[4:0];
                    case (s_axis_tuser)
                        prq_pkg::OP_ENQUEUE: begin
                            if (r_queued[s_axis_tdata[4:0]]) begin
                                n_res_st = 1'b1;
                                n_state  = prq_pkg::S_RESP;
                            end else begin
                                n_state = prq_pkg::S_APP0;
                            end
                        end
                        prq_pkg::OP_REMOVE: begin
                            if (s_axis_tdata[4:0] == prq_pkg::IDLE_TASK ||
                                !r_queued[s_axis_tdata[4:0]]) begin
                                n_res_st = 1'b1;
                                n_state  = prq_pkg::S_RESP;
                            end else begin
                                n_state = prq_pkg::S_UL0;
                            end
                        end
                        prq_pkg::OP_DISPATCH: begin
                            n_state = prq_pkg::S_D0;
                        end
                        default: begin
                            n_res_st = 1'b1;
                            n_state  = prq_pkg::S_RESP;
                        end
                    endcase
                end
            end

            // append: read level entry
            prq_pkg::S_APP0: begin
                lm_rd_en   = 1'b1;
                lm_rd_addr = r_app_lv;
                n_state    = prq_pkg::S_APP1;
            end

            // append: link behind old tail, update level entry and bitmap
            prq_pkg::S_APP1: begin
                n_app_pv     = lm_rd.tail;
                lm_wr.en     = 1'b1;
                lm_wr.addr   = r_app_lv;
                lm_wr.ent.tail = r_app_t;
                lm_wr.ent.head = lv_nonempty ? lm_rd.head : r_app_t;
                if (lv_nonempty) begin
                    tm_wr.en_next  = 1'b1;
                    tm_wr.addr     = lm_rd.tail;
                    tm_wr.ent.next = r_app_t;
                end
                map_ctl.set   = 1'b1;
                map_ctl.level = r_app_lv;
                n_queued[r_app_t] = 1'b1;
                n_state = prq_pkg::S_APP2;
            end

            // append: write the new task's own entry
            prq_pkg::S_APP2: begin
                tm_wr.en_next  = 1'b1;
                tm_wr.en_prev  = 1'b1;
                tm_wr.en_lvl   = 1'b1;
                tm_wr.addr     = r_app_t;
                tm_wr.ent.next = prq_pkg::IDLE_TASK;
                tm_wr.ent.prev = r_app_pv;
                tm_wr.ent.lvl  = r_app_lv;
                n_state = prq_pkg::S_RESP;
            end

            // unlink: read task entry
            prq_pkg::S_UL0: begin
                tm_rd_en   = 1'b1;
                tm_rd_addr = r_ul_t;
                n_state    = prq_pkg::S_UL1;
            end

            // unlink: keep links, read its level entry
            prq_pkg::S_UL1: begin
                n_p        = tm_rd.prev;
                n_n        = tm_rd.next;
                n_lv       = tm_rd.lvl;
                lm_rd_en   = 1'b1;
                lm_rd_addr = tm_rd.lvl;
                n_state    = prq_pkg::S_UL2;
            end

            prq_pkg::S_UL2: begin
                n_queued[r_ul_t] = 1'b0;
                n_state = (r_op == prq_pkg::OP_DISPATCH) ? prq_pkg::S_DAPP
                                                         : prq_pkg::S_RESP;
                if (at_head && at_tail) begin
                    map_ctl.clr   = 1'b1;
                    map_ctl.level = r_lv;
                end else if (at_head) begin
                    lm_wr.en       = 1'b1;
                    lm_wr.addr     = r_lv;
                    lm_wr.ent.head = r_n;
                    lm_wr.ent.tail = lm_rd.tail;
                end else if (at_tail) begin
                    // predecessor becomes the tail
                    lm_wr.en       = 1'b1;
                    lm_wr.addr     = r_lv;
                    lm_wr.ent.head = lm_rd.head;
                    lm_wr.ent.tail = r_p;
                    tm_wr.en_next  = 1'b1;
                    tm_wr.addr     = r_p;
                    tm_wr.ent.next = prq_pkg::IDLE_TASK;
                end else begin
                    tm_wr.en_next  = 1'b1;
                    tm_wr.addr     = r_p;
                    tm_wr.ent.next = r_n;
                    n_state        = prq_pkg::S_UL3;
                end
            end

            // unlink from the middle: back link of the successor
            prq_pkg::S_UL3: begin
                tm_wr.en_prev  = 1'b1;
                tm_wr.addr     = r_n;
                tm_wr.ent.prev = r_p;
                n_state = (r_op == prq_pkg::OP_DISPATCH) ? prq_pkg::S_DAPP
                                                         : prq_pkg::S_RESP;
            end

            // dispatch: group search
            prq_pkg::S_D0: begin
                map_find = 1'b1;
                n_state  = prq_pkg::S_D1;
            end

            // dispatch: top level known, decide
            prq_pkg::S_D1: begin
                n_res_next = r_run;
                n_res_sw   = 1'b0;
                if (take) begin
                    lm_rd_en   = 1'b1;
                    lm_rd_addr = top_lv;
                    n_state    = prq_pkg::S_D2;
                end else begin
                    n_state = prq_pkg::S_RESP;
                end
            end

            // dispatch: head of top level picked
            prq_pkg::S_D2: begin
                n_res_next = lm_rd.head;
                n_res_sw   = (lm_rd.head != r_run);
                n_ul_t     = lm_rd.head;
                n_state    = (lm_rd.head != prq_pkg::IDLE_TASK) ? prq_pkg::S_UL0
                                                                : prq_pkg::S_DAPP;
            end

            // dispatch: requeue the replaced task
            prq_pkg::S_DAPP: begin
                n_app_t  = r_run;
                n_app_lv = r_rlv;
                if (r_res_sw && r_mode != prq_pkg::MODE_EXIT && !r_queued[r_run]) begin
                    n_state = prq_pkg::S_APP0;
                end else begin
                    n_state = prq_pkg::S_RESP;
                end
            end

            prq_pkg::S_RESP: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {1'b0, r_res_st, r_res_sw, r_res_next};
                    n_state   = prq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = prq_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
